>>> rtl/core/cpr_pkg.sv
`timescale 1ns / 1ps

package cpr_pkg;

    localparam int FRAMES      = 16;
    localparam int PAGE_BITS   = 20;
    localparam int FIDX_W      = $clog2(FRAMES);
    localparam int CNT_W       = $clog2(FRAMES + 1);
    localparam int CFG_W       = 5;
    localparam int FRAME_OUT_W = 4;
    localparam int TOTAL_W     = 32;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic search_start;
        logic search_step;
        logic hit_take;
        logic miss_take;
        logic sweep_step;
        logic evict;
        logic out_load;
    } cpr_cmd_t;

    typedef struct packed {
        logic hit_found;
        logic search_last;
        logic sweep_stop;
    } cpr_status_t;

endpackage

>>> rtl/core/cpr_datapath.sv
`timescale 1ns / 1ps

module cpr_datapath
    import cpr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic [PAGE_BITS-1:0]   page_number,
    input  cpr_cmd_t               cmd,
    output cpr_status_t            status,
    output logic                   hit,
    output logic [FRAME_OUT_W-1:0] frame,
    output logic                   evicted_valid,
    output logic [PAGE_BITS-1:0]   evicted_page,
    output logic [TOTAL_W-1:0]     request_total,
    output logic [TOTAL_W-1:0]     fault_total
);

    logic [PAGE_BITS-1:0]   mem [FRAMES];
    logic [PAGE_BITS-1:0]   rd_data_reg;
    logic [FIDX_W-1:0]      rd_addr;

    logic [CFG_W-1:0]       frames_in_use_reg;
    logic [CNT_W-1:0]       n_eff;
    logic [FRAMES-1:0]      valid_reg;
    logic [FRAMES-1:0]      ref_reg;
    logic [FIDX_W-1:0]      hand_reg;
    logic [CNT_W-1:0]       hand_inc;
    logic [FIDX_W-1:0]      hand_adv;
    logic [TOTAL_W-1:0]     req_cnt_reg;
    logic [TOTAL_W-1:0]     fault_cnt_reg;

    logic [CNT_W-1:0]       idx_reg;
    logic [FIDX_W-1:0]      cmp_idx_reg;
    logic                   cmp_en_reg;
    logic [PAGE_BITS-1:0]   page_reg;

    logic                   res_hit_reg;
    logic [FIDX_W-1:0]      res_frame_reg;
    logic                   res_ev_valid_reg;
    logic [PAGE_BITS-1:0]   res_ev_page_reg;

    logic                   out_hit_reg;
    logic [FRAME_OUT_W-1:0] out_frame_reg;
    logic                   out_ev_valid_reg;
    logic [PAGE_BITS-1:0]   out_ev_page_reg;
    logic [TOTAL_W-1:0]     out_req_reg;
    logic [TOTAL_W-1:0]     out_fault_reg;

    always_comb
    begin
        if (frames_in_use_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (int'(frames_in_use_reg) > FRAMES)
        begin
            n_eff = CNT_W'(FRAMES);
        end
        else
        begin
            n_eff = CNT_W'(frames_in_use_reg);
        end
    end

    assign hand_inc = CNT_W'(hand_reg) + CNT_W'(1);
    assign hand_adv = (hand_inc >= n_eff) ? '0 : hand_inc[FIDX_W-1:0];
    assign rd_addr  = cmd.sweep_step ? hand_adv : idx_reg[FIDX_W-1:0];

    assign status.hit_found   = cmp_en_reg && valid_reg[cmp_idx_reg]
                                && (rd_data_reg == page_reg);
    assign status.search_last = cmp_en_reg
                                && ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == n_eff);
    assign status.sweep_stop  = !ref_reg[hand_adv];

    // frame table
    always_ff @(posedge clk)
    begin
        if (cmd.evict)
        begin
            mem[hand_reg] <= page_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= CFG_W'(FRAMES);
            valid_reg         <= '0;
            ref_reg           <= '0;
            hand_reg          <= FIDX_W'(FRAMES - 1);
            req_cnt_reg       <= '0;
            fault_cnt_reg     <= '0;
            idx_reg           <= '0;
            cmp_en_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                frames_in_use_reg <= cfg_wdata;
            end
            if (cmd.search_start)
            begin
                idx_reg    <= '0;
                cmp_en_reg <= 1'b0;
                if (req_cnt_reg != TOTAL_MAX)
                begin
                    req_cnt_reg <= req_cnt_reg + TOTAL_W'(1);
                end
            end
            else if (cmd.search_step)
            begin
                if (idx_reg < n_eff)
                begin
                    cmp_en_reg <= 1'b1;
                    idx_reg    <= idx_reg + CNT_W'(1);
                end
                else
                begin
                    cmp_en_reg <= 1'b0;
                end
            end
            if (cmd.hit_take)
            begin
                ref_reg[cmp_idx_reg] <= 1'b1;
            end
            if (cmd.miss_take && (fault_cnt_reg != TOTAL_MAX))
            begin
                fault_cnt_reg <= fault_cnt_reg + TOTAL_W'(1);
            end
            if (cmd.sweep_step)
            begin
                hand_reg <= hand_adv;
                if (ref_reg[hand_adv])
                begin
                    ref_reg[hand_adv] <= 1'b0;
                end
            end
            if (cmd.evict)
            begin
                valid_reg[hand_reg] <= 1'b1;
                ref_reg[hand_reg]   <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search_start)
        begin
            page_reg <= page_number;
        end
        if (cmd.search_step)
        begin
            cmp_idx_reg <= idx_reg[FIDX_W-1:0];
        end
        if (cmd.hit_take)
        begin
            res_hit_reg      <= 1'b1;
            res_frame_reg    <= cmp_idx_reg;
            res_ev_valid_reg <= 1'b0;
            res_ev_page_reg  <= '0;
        end
        if (cmd.evict)
        begin
            res_hit_reg      <= 1'b0;
            res_frame_reg    <= hand_reg;
            res_ev_valid_reg <= valid_reg[hand_reg];
            res_ev_page_reg  <= valid_reg[hand_reg] ? rd_data_reg : '0;
        end
        if (cmd.out_load)
        begin
            out_hit_reg      <= res_hit_reg;
            out_frame_reg    <= FRAME_OUT_W'(res_frame_reg);
            out_ev_valid_reg <= res_ev_valid_reg;
            out_ev_page_reg  <= res_ev_page_reg;
            out_req_reg      <= req_cnt_reg;
            out_fault_reg    <= fault_cnt_reg;
        end
    end

    assign hit           = out_hit_reg;
    assign frame         = out_frame_reg;
    assign evicted_valid = out_ev_valid_reg;
    assign evicted_page  = out_ev_page_reg;
    assign request_total = out_req_reg;
    assign fault_total   = out_fault_reg;

endmodule

>>> rtl/core/cpr_ctrl.sv
`timescale 1ns / 1ps

module cpr_ctrl
    import cpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  cpr_status_t status,
    output cpr_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SWEEP,
        S_EVICT,
        S_POST
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.search_start = 1'b1;
                    state_next       = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                priority if (status.hit_found)
                begin
                    cmd.hit_take = 1'b1;
                    state_next   = S_POST;
                end
                else if (status.search_last)
                begin
                    cmd.miss_take = 1'b1;
                    state_next    = S_SWEEP;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_stop)
                begin
                    state_next = S_EVICT;
                end
            end
            S_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = S_POST;
            end
            S_POST:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/clock_page_replacement.sv
`timescale 1ns / 1ps

// Clock (second-chance) page replacement unit.
// Input channel: in_valid / in_stall carry one page request per item
// (page_number). An item is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall carry one result item per request:
// hit, frame, evicted_valid, evicted_page, request_total, fault_total.
// Configuration: cfg_we with cfg_wdata writes frames_in_use; write it only
// while no request is in flight.
// A hit on frame k ends the lookup once frames 0 to k are compared.
// A miss runs the lookup over all n managed frames and then steps the
// clock hand (1 to n+1 steps). The lookup reads the frame table one
// entry per cycle through its single registered read port; the sweep
// moves the hand one frame per cycle. One request is processed at a
// time and the next is accepted in the cycle after the result is loaded.
// Reset clears valid and reference bits, both counts, and sets the hand
// to the last frame; the page table itself is not cleared.
// A stalled result holds; the unit then finishes the next request and
// waits with in_stall high until the output register is free.
module clock_page_replacement
    import cpr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PAGE_BITS-1:0]   page_number,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   hit,
    output logic [FRAME_OUT_W-1:0] frame,
    output logic                   evicted_valid,
    output logic [PAGE_BITS-1:0]   evicted_page,
    output logic [TOTAL_W-1:0]     request_total,
    output logic [TOTAL_W-1:0]     fault_total
);

    cpr_cmd_t    cmd;
    cpr_status_t status;

    cpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    cpr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .page_number   (page_number),
        .cmd           (cmd),
        .status        (status),
        .hit           (hit),
        .frame         (frame),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .request_total (request_total),
        .fault_total   (fault_total)
    );

endmodule

>>> rtl/core/cpr_checker.sv
`timescale 1ns / 1ps

module cpr_checker
    import cpr_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic                   hit,
    input logic [FRAME_OUT_W-1:0] frame,
    input logic                   evicted_valid,
    input logic [PAGE_BITS-1:0]   evicted_page,
    input logic [TOTAL_W-1:0]     request_total,
    input logic [TOTAL_W-1:0]     fault_total
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(frame)
            && $stable(evicted_page) && $stable(request_total))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while previous still in flight");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !evicted_valid)
        else $error("hit reported an eviction");

    a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted_valid |-> evicted_page == '0)
        else $error("evicted page nonzero without eviction");

    a_fault_le_req: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fault_total <= request_total)
        else $error("fault count exceeds request count");

endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (.*);
